// ----- design/ptm_pkg.sv -----
// ----------------------------------------------------------------------------
// ptm_pkg: shared types and constants of the polynomial term table
// Field widths, operation codes, the memory entry layout and the structs that
// pass between the sequencer and the modular arithmetic unit.
// ----------------------------------------------------------------------------
package ptm_pkg;

   localparam int MOD_W    = 16;   // modulus and residue width
   localparam int OPND_W   = 32;   // width of signed input operands
   localparam int EXP_W    = 4;    // bits per exponent
   localparam int NUM_VARS = 4;    // variables per term
   localparam int KEY_W    = EXP_W * NUM_VARS;
   localparam int VC_W     = 3;    // var_count register width
   localparam int STEP_W   = 6;    // step counter of the arithmetic unit

   localparam logic [MOD_W-1:0] MODULUS_RESET   = 16'd2;
   localparam logic [VC_W-1:0]  VAR_COUNT_RESET = 3'd4;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_EVAL  = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic {
      REG_MODULUS   = 1'b0,
      REG_VAR_COUNT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [KEY_W-1:0] exps;
      logic [MOD_W-1:0] coef;
   } term_entry_type;

   // Request to the modular unit: either a reduction of a 32-bit magnitude
   // (negated at the end when neg is set) or a product a * b mod m.
   typedef struct packed {
      logic              start;
      logic              mul;
      logic              neg;
      logic [MOD_W-1:0]  a;
      logic [OPND_W-1:0] b;
   } mu_req_type;

   typedef struct packed {
      logic             done;
      logic [MOD_W-1:0] r;
   } mu_rsp_type;

endpackage

// ----- design/ptm_if.sv -----
// ----------------------------------------------------------------------------
// ptm_if: item channels of the polynomial term table
// Request channel carries one action item, response channel one result item.
// ----------------------------------------------------------------------------
interface ptm_req_if;
   logic                 valid;
   logic                 ready;
   logic [1:0]           action;
   logic signed [31:0]   coefficient;
   logic [3:0]           exp_0;
   logic [3:0]           exp_1;
   logic [3:0]           exp_2;
   logic [3:0]           exp_3;
   logic signed [31:0]   x_0;
   logic signed [31:0]   x_1;
   logic signed [31:0]   x_2;
   logic signed [31:0]   x_3;

   modport source (output valid, action, coefficient, exp_0, exp_1, exp_2, exp_3,
                   x_0, x_1, x_2, x_3, input ready);
   modport sink   (input valid, action, coefficient, exp_0, exp_1, exp_2, exp_3,
                   x_0, x_1, x_2, x_3, output ready);
endinterface

interface ptm_rsp_if #(parameter int MAX_TERMS = 16);
   localparam int CNT_W = $clog2(MAX_TERMS + 1);
   logic             valid;
   logic             ready;
   logic [15:0]      value;
   logic             status;
   logic [CNT_W-1:0] stored_terms;

   modport source (output valid, value, status, stored_terms, input ready);
   modport sink   (input valid, value, status, stored_terms, output ready);
endinterface

// ----- design/ptm_term_mem.sv -----
// ----------------------------------------------------------------------------
// ptm_term_mem: term storage
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module ptm_term_mem #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                    clock,
   input  logic                    we,
   input  logic [ADDR_W-1:0]       waddr,
   input  ptm_pkg::term_entry_type wdata,
   input  logic [ADDR_W-1:0]       raddr,
   output ptm_pkg::term_entry_type rdata
);

   ptm_pkg::term_entry_type mem [DEPTH];
   ptm_pkg::term_entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/ptm_mod_unit.sv -----
// ----------------------------------------------------------------------------
// ptm_mod_unit: bit-serial modular arithmetic unit
// Reduces a 32-bit magnitude mod m in 32 steps, or forms a * b mod m in
// 16 steps, one bit per cycle with a double-and-add recurrence.
// ----------------------------------------------------------------------------
module ptm_mod_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ptm_pkg::MOD_W-1:0]      m,
   input  ptm_pkg::mu_req_type            mreq,
   output ptm_pkg::mu_rsp_type            mrsp
);

   localparam int MW = ptm_pkg::MOD_W;
   localparam int OW = ptm_pkg::OPND_W;
   localparam int SW = ptm_pkg::STEP_W;

   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic          mul_ff, mul_in;
   logic          neg_ff, neg_in;
   logic [MW-1:0] a_ff, a_in;
   logic [OW-1:0] sh_ff, sh_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   logic [MW-1:0] r_ff, r_in;

   logic [MW:0]   dbl;
   logic [MW-1:0] addend;
   logic [MW:0]   sum;

   // One step: r = (2r mod m + addend) mod m. Both terms stay below m, but for an addend of one when m is one.
   always_comb begin
      dbl = {r_ff, 1'b0};
      if (dbl >= {1'b0, m}) begin
         dbl = dbl - {1'b0, m};
      end
      if (mul_ff) begin
         addend = sh_ff[OW-1] ? a_ff : '0;
      end else begin
         addend = {{(MW-1){1'b0}}, sh_ff[OW-1]};
      end
      sum = {1'b0, dbl[MW-1:0]} + {1'b0, addend};
      if (sum >= {1'b0, m}) begin
         sum = sum - {1'b0, m};
      end
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      mul_in  = mul_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      sh_in   = sh_ff;
      cnt_in  = cnt_ff;
      r_in    = r_ff;
      if (mreq.start) begin
         busy_in = 1'b1;
         mul_in  = mreq.mul;
         neg_in  = mreq.neg;
         a_in    = mreq.a;
         r_in    = '0;
         if (mreq.mul) begin
            sh_in  = {mreq.b[MW-1:0], {(OW-MW){1'b0}}};
            cnt_in = SW'(MW);
         end else begin
            sh_in  = mreq.b;
            cnt_in = SW'(OW);
         end
      end else if (busy_ff) begin
         r_in   = sum[MW-1:0];
         sh_in  = {sh_ff[OW-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == SW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      mul_ff <= mul_in;
      neg_ff <= neg_in;
      a_ff   <= a_in;
      sh_ff  <= sh_in;
      cnt_ff <= cnt_in;
      r_ff   <= r_in;
   end

   assign mrsp.done = done_ff;
   assign mrsp.r    = (neg_ff && (r_ff != '0)) ? (m - r_ff) : r_ff;

endmodule

// ----- design/poly_term_table_mod_eval.sv -----
// ----------------------------------------------------------------------------
// poly_term_table_mod_eval: polynomial term table with modular evaluation
// Stores up to MAX_TERMS terms (coefficient and four exponents) and evaluates
// the polynomial at a point modulo a programmable modulus.
// ----------------------------------------------------------------------------
// The block takes one item at a time and returns one result item for each.
// A clear item or an unknown action goes straight to the result state, from
// which the block returns to idle to accept the next item. An add item first
// reduces its coefficient, then scans the stored terms through the term
// memory, with a read state and a compare state per term; a match re-reduces
// the stored coefficient before the sum is written back. An evaluate item
// reduces the four coordinates, and then for each stored term reads and
// reduces the coefficient, multiplies it by each variable in use once per
// unit of that variable's exponent, since each power is built by repeated
// multiplication, and adds the term into the sum. The run time is set by the
// single bit-serial modular unit, which every reduction and product goes
// through one bit per cycle. The term memory is read at one address and
// written at one address; reads and writes of the same item never overlap,
// because a write happens only as the item finishes. A zero modulus behaves
// as modulus one. Configuration registers: modulus at byte address 0 and
// var_count at byte address 4.
// ----------------------------------------------------------------------------
module poly_term_table_mod_eval #(
   parameter int MAX_TERMS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   ptm_req_if.sink                   req_bus,
   ptm_rsp_if.source                 rsp_bus,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [2:0]                paddr,
   input  logic [31:0]               pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);

   localparam int CNT_W  = $clog2(MAX_TERMS + 1);
   localparam int ADDR_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
   localparam int MW     = ptm_pkg::MOD_W;
   localparam int OW     = ptm_pkg::OPND_W;
   localparam int EW     = ptm_pkg::EXP_W;
   localparam int NV     = ptm_pkg::NUM_VARS;
   localparam int KW     = ptm_pkg::KEY_W;
   localparam int VW     = ptm_pkg::VC_W;

   typedef enum logic [11:0] {
      ST_IDLE    = 12'b0000_0000_0001,
      ST_RED_C   = 12'b0000_0000_0010,
      ST_SCAN_RD = 12'b0000_0000_0100,
      ST_SCAN_CK = 12'b0000_0000_1000,
      ST_MATCH   = 12'b0000_0001_0000,
      ST_RED_X   = 12'b0000_0010_0000,
      ST_EV_RD   = 12'b0000_0100_0000,
      ST_EV_LD   = 12'b0000_1000_0000,
      ST_EV_COEF = 12'b0001_0000_0000,
      ST_EV_POW  = 12'b0010_0000_0000,
      ST_EV_MUL  = 12'b0100_0000_0000,
      ST_DONE    = 12'b1000_0000_0000
   } state_type;

   // Configuration registers.
   logic [MW-1:0] modulus_ff;
   logic [VW-1:0] var_count_ff;
   logic          cfg_write;

   assign cfg_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= ptm_pkg::MODULUS_RESET;
         var_count_ff <= ptm_pkg::VAR_COUNT_RESET;
      end else if (cfg_write) begin
         if (paddr[2] == ptm_pkg::REG_MODULUS) begin
            modulus_ff <= pwdata[MW-1:0];
         end else begin
            var_count_ff <= pwdata[VW-1:0];
         end
      end
   end

   assign prdata = (paddr[2] == ptm_pkg::REG_MODULUS) ? {{(32-MW){1'b0}}, modulus_ff}
                                                      : {{(32-VW){1'b0}}, var_count_ff};

   // Effective modulus and variable count.
   logic [MW-1:0] m_act;
   logic [VW-1:0] nv_act;

   assign m_act  = (modulus_ff == '0) ? MW'(1) : modulus_ff;
   assign nv_act = (var_count_ff > VW'(NV)) ? VW'(NV) : var_count_ff;

   // Sequencer state.
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [VW-1:0]    j_ff, j_in;
   logic [EW-1:0]    k_ff, k_in;
   logic [KW-1:0]    key_ff, key_in;
   logic [MW-1:0]    c_ff, c_in;
   logic [MW-1:0]    t_ff, t_in;
   logic [MW-1:0]    acc_ff, acc_in;
   logic [OW-1:0]    xraw_ff [NV];
   logic [OW-1:0]    xraw_in [NV];
   logic [MW-1:0]    xr_ff [NV];
   logic [MW-1:0]    xr_in [NV];
   logic [MW-1:0]    res_value_ff, res_value_in;
   logic             res_status_ff, res_status_in;
   ptm_pkg::term_entry_type ent_ff, ent_in;

   // Result register.
   logic             rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0]    rsp_value_ff, rsp_value_in;
   logic             rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0] rsp_terms_ff, rsp_terms_in;

   // Memory and arithmetic unit connections.
   logic                    mem_we;
   logic [ADDR_W-1:0]       mem_waddr;
   ptm_pkg::term_entry_type mem_wdata;
   ptm_pkg::term_entry_type mem_rdata;
   ptm_pkg::mu_req_type     mreq;
   ptm_pkg::mu_rsp_type     mrsp;

   logic             req_take;
   logic [KW-1:0]    req_key;
   logic [MW:0]      csum;
   logic [MW:0]      asum;
   logic [EW-1:0]    cur_exp;
   logic [1:0]       jv;

   assign req_take = req_bus.valid && req_bus.ready;
   assign req_key  = {req_bus.exp_3, req_bus.exp_2, req_bus.exp_1, req_bus.exp_0};
   assign jv       = j_ff[1:0];
   assign cur_exp  = ent_ff.exps[jv*EW +: EW];

   // Modular sums: the stored coefficient plus the new one, and the
   // running evaluation sum plus the finished term.
   always_comb begin
      csum = {1'b0, mrsp.r} + {1'b0, c_ff};
      if (csum >= {1'b0, m_act}) begin
         csum = csum - {1'b0, m_act};
      end
      asum = {1'b0, acc_ff} + {1'b0, t_ff};
      if (asum >= {1'b0, m_act}) begin
         asum = asum - {1'b0, m_act};
      end
   end

   always_comb begin
      state_in      = state_ff;
      total_in      = total_ff;
      idx_in        = idx_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      key_in        = key_ff;
      c_in          = c_ff;
      t_in          = t_ff;
      acc_in        = acc_ff;
      xraw_in       = xraw_ff;
      xr_in         = xr_ff;
      ent_in        = ent_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_terms_in  = rsp_terms_ff;
      mem_we        = 1'b0;
      mem_waddr     = idx_ff[ADDR_W-1:0];
      mem_wdata     = '{exps: key_ff, coef: c_ff};
      mreq          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               res_value_in  = '0;
               res_status_in = 1'b0;
               case (req_bus.action)
                  ptm_pkg::ACT_CLEAR: begin
                     total_in = '0;
                     state_in = ST_DONE;
                  end
                  ptm_pkg::ACT_ADD: begin
                     key_in     = req_key;
                     mreq.start = 1'b1;
                     mreq.neg   = req_bus.coefficient[OW-1];
                     mreq.b     = req_bus.coefficient[OW-1] ? (-req_bus.coefficient)
                                                            : req_bus.coefficient;
                     state_in   = ST_RED_C;
                  end
                  ptm_pkg::ACT_EVAL: begin
                     xraw_in[0] = req_bus.x_0;
                     xraw_in[1] = req_bus.x_1;
                     xraw_in[2] = req_bus.x_2;
                     xraw_in[3] = req_bus.x_3;
                     j_in       = '0;
                     mreq.start = 1'b1;
                     mreq.neg   = req_bus.x_0[OW-1];
                     mreq.b     = req_bus.x_0[OW-1] ? (-req_bus.x_0) : req_bus.x_0;
                     state_in   = ST_RED_X;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         ST_RED_C: begin
            if (mrsp.done) begin
               c_in     = mrsp.r;
               idx_in   = '0;
               state_in = ST_SCAN_RD;
            end
         end

         // The read of entry idx is issued here; its data arrives in SCAN_CK.
         ST_SCAN_RD: begin
            if (idx_ff == total_ff) begin
               if (total_ff < CNT_W'(MAX_TERMS)) begin
                  mem_we    = 1'b1;
                  mem_waddr = total_ff[ADDR_W-1:0];
                  total_in  = total_ff + 1'b1;
               end else begin
                  res_status_in = 1'b1;
               end
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN_CK;
            end
         end

         ST_SCAN_CK: begin
            if (mem_rdata.exps == key_ff) begin
               // The stored coefficient may predate a modulus change.
               mreq.start = 1'b1;
               mreq.b     = {{(OW-MW){1'b0}}, mem_rdata.coef};
               state_in   = ST_MATCH;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SCAN_RD;
            end
         end

         ST_MATCH: begin
            if (mrsp.done) begin
               mem_we         = 1'b1;
               mem_wdata.coef = csum[MW-1:0];
               state_in       = ST_DONE;
            end
         end

         ST_RED_X: begin
            if (mrsp.done) begin
               xr_in[jv] = mrsp.r;
               if (jv == 2'(NV - 1)) begin
                  acc_in   = '0;
                  idx_in   = '0;
                  state_in = ST_EV_RD;
               end else begin
                  j_in       = j_ff + 1'b1;
                  mreq.start = 1'b1;
                  mreq.neg   = xraw_ff[jv + 2'd1][OW-1];
                  mreq.b     = xraw_ff[jv + 2'd1][OW-1] ? (-xraw_ff[jv + 2'd1])
                                                        : xraw_ff[jv + 2'd1];
               end
            end
         end

         ST_EV_RD: begin
            if (idx_ff == total_ff) begin
               res_value_in = acc_ff;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_EV_LD;
            end
         end

         ST_EV_LD: begin
            ent_in     = mem_rdata;
            mreq.start = 1'b1;
            mreq.b     = {{(OW-MW){1'b0}}, mem_rdata.coef};
            state_in   = ST_EV_COEF;
         end

         ST_EV_COEF: begin
            if (mrsp.done) begin
               t_in     = mrsp.r;
               j_in     = '0;
               k_in     = '0;
               state_in = ST_EV_POW;
            end
         end

         // Multiply the term by x_j once per unit of exponent, variable by
         // variable; unused variables are skipped entirely.
         ST_EV_POW: begin
            if (j_ff >= nv_act) begin
               acc_in   = asum[MW-1:0];
               idx_in   = idx_ff + 1'b1;
               state_in = ST_EV_RD;
            end else if (k_ff == cur_exp) begin
               j_in = j_ff + 1'b1;
               k_in = '0;
            end else begin
               mreq.start = 1'b1;
               mreq.mul   = 1'b1;
               mreq.a     = t_ff;
               mreq.b     = {{(OW-MW){1'b0}}, xr_ff[jv]};
               state_in   = ST_EV_MUL;
            end
         end

         ST_EV_MUL: begin
            if (mrsp.done) begin
               t_in     = mrsp.r;
               k_in     = k_ff + 1'b1;
               state_in = ST_EV_POW;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_terms_in  = total_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff        <= idx_in;
      j_ff          <= j_in;
      k_ff          <= k_in;
      key_ff        <= key_in;
      c_ff          <= c_in;
      t_ff          <= t_in;
      acc_ff        <= acc_in;
      xraw_ff       <= xraw_in;
      xr_ff         <= xr_in;
      ent_ff        <= ent_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_terms_ff  <= rsp_terms_in;
   end

   assign req_bus.ready        = (state_ff == ST_IDLE);
   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.value        = rsp_value_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.stored_terms = rsp_terms_ff;

   ptm_term_mem #(
      .DEPTH  (MAX_TERMS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (idx_ff[ADDR_W-1:0]),
      .rdata (mem_rdata)
   );

   ptm_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .m     (m_act),
      .mreq  (mreq),
      .mrsp  (mrsp)
   );

endmodule

// ----- design/ptm_checker.sv -----
// ----------------------------------------------------------------------------
// ptm_checker: port-level checks of the polynomial term table
// Watches the item channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
module ptm_checker #(
   parameter int MAX_TERMS = 16
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [15:0]                      rsp_value,
   input logic                             rsp_status,
   input logic [$clog2(MAX_TERMS+1)-1:0]   rsp_terms
);

   localparam int CNT_W = $clog2(MAX_TERMS + 1);

   // Items are handled one at a time: no second item right after one.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("item taken back to back");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_terms <= CNT_W'(MAX_TERMS)))
      else $error("stored term count above table size");

   // A dropped term comes only from an add, whose value is zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_value == 16'd0))
      else $error("full flag with nonzero value");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled result item changed");

endmodule

bind poly_term_table_mod_eval ptm_checker #(
   .MAX_TERMS (MAX_TERMS)
) u_ptm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .rsp_value  (rsp_bus.value),
   .rsp_status (rsp_bus.status),
   .rsp_terms  (rsp_bus.stored_terms)
);

// ----- tb/sv/poly_term_table_mod_eval_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// poly_term_table_mod_eval_test: self-checking test of the term table
// Drives clear, add, evaluate and unknown items through the request channel.
// The first items come from a directed table, and the rest are random.
// Every result item is checked against a local model of the table and its
// modular arithmetic, or against a result typed in by hand for directed rows.
// The run steps through several modulus and var_count settings and several
// patterns of sender gaps and receiver stalls.
module poly_term_table_mod_eval_test;

   // The watchdog limit leaves a wide margin on top of the slowest evaluate
   // item and on top of receiver stalls.
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int TABLE_DEPTH    = 16;
   localparam int RANDOM_ITEMS   = 1925;

   typedef struct {
      ptm_pkg::action_type act;
      logic signed [31:0] coef;
      logic [3:0]        e [4];
      logic signed [31:0] x [4];
      bit                known;     // expected result typed in by hand
      logic [15:0]       k_value;
      logic              k_status;
      logic [4:0]        k_terms;
   } term_item_type;

   typedef struct {
      logic [15:0] value;
      logic        status;
      logic [4:0]  terms;
   } eval_result_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   ptm_req_if                           req ();
   ptm_rsp_if #(.MAX_TERMS(TABLE_DEPTH)) rsp ();

   poly_term_table_mod_eval #(.MAX_TERMS(TABLE_DEPTH)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req.sink),
      .rsp_bus (rsp.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Clock with a 2 ns period.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Local copy of the table and of the configuration registers.
   logic [15:0] coef_mem [TABLE_DEPTH];
   logic [15:0] key_mem  [TABLE_DEPTH];
   int          term_cnt;
   logic [15:0] cfg_modulus;
   logic [2:0]  cfg_var_count;

   eval_result_type expected_q [$];
   int          err_count;
   int          sent_count;
   int          got_count;
   int          eval_count;
   int          full_count;
   int          send_gap_pct;
   int          stall_pct;
   int          quiet_cycles;

   // Reduce a signed 32-bit value into 0 .. m-1. SystemVerilog remainder
   // truncates toward zero, so negative remainders are lifted by m.
   function automatic longint unsigned reduce_signed(logic signed [31:0] v,
                                                     longint unsigned m);
      longint r;
      r = longint'(v) % longint'(m);
      if (r < 0) r += longint'(m);
      return longint'(r);
   endfunction

   // Power by repeated squaring; zero to the power zero gives one, reduced mod m.
   function automatic longint unsigned pow_mod(longint unsigned b, int unsigned e,
                                               longint unsigned m);
      longint unsigned r;
      r = 1 % m;
      while (e != 0) begin
         if (e[0]) r = (r * b) % m;
         b = (b * b) % m;
         e = e >> 1;
      end
      return r;
   endfunction

   // Applies one accepted item to the local table and returns its result.
   function automatic eval_result_type apply_item(term_item_type it);
      eval_result_type res;
      longint unsigned m;
      longint unsigned c;
      longint unsigned acc;
      longint unsigned t;
      longint unsigned xs [4];
      logic [15:0]     key;
      bit              found;
      int              nv;
      m = (cfg_modulus == 0) ? 1 : cfg_modulus;
      res.value  = '0;
      res.status = 1'b0;
      found      = 1'b0;
      case (it.act)
         ptm_pkg::ACT_CLEAR: begin
            term_cnt = 0;
         end
         ptm_pkg::ACT_ADD: begin
            c   = reduce_signed(it.coef, m);
            key = {it.e[3], it.e[2], it.e[1], it.e[0]};
            for (int i = 0; i < term_cnt; i++) begin
               if (!found && key_mem[i] == key) begin
                  coef_mem[i] = 16'((coef_mem[i] % m + c) % m);
                  found = 1'b1;
               end
            end
            if (!found) begin
               if (term_cnt < TABLE_DEPTH) begin
                  coef_mem[term_cnt] = 16'(c);
                  key_mem[term_cnt]  = key;
                  term_cnt++;
               end else begin
                  res.status = 1'b1;
               end
            end
         end
         ptm_pkg::ACT_EVAL: begin
            // A var_count above four saturates, and zero uses no variable.
            nv  = (cfg_var_count > 4) ? 4 : cfg_var_count;
            acc = 0;
            for (int j = 0; j < 4; j++) xs[j] = reduce_signed(it.x[j], m);
            for (int i = 0; i < term_cnt; i++) begin
               t = 1 % m;
               for (int j = 0; j < nv; j++)
                  t = (t * pow_mod(xs[j], 32'(key_mem[i][4*j +: 4]), m)) % m;
               // Stored coefficients are reduced again by the current modulus.
               t   = (t * (coef_mem[i] % m)) % m;
               acc = (acc + t) % m;
            end
            res.value = 16'(acc);
         end
         default: begin
         end
      endcase
      res.terms = 5'(term_cnt);
      return res;
   endfunction

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(9))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return -32'sd1;
         3: return 32'($urandom_range(20));
         4: return -32'($urandom_range(20));
         default: return $urandom;
      endcase
   endfunction

   // Mostly well-formed traffic: adds and evaluates over a small pool of
   // exponent vectors, so that merges, a full table and clears all happen.
   // Exponents stay small most of the time to keep evaluation short.
   function automatic term_item_type random_item();
      term_item_type it;
      int         r;
      r = $urandom_range(99);
      if (r < 8)       it.act = ptm_pkg::ACT_CLEAR;
      else if (r < 55) it.act = ptm_pkg::ACT_ADD;
      else if (r < 95) it.act = ptm_pkg::ACT_EVAL;
      else             it.act = ptm_pkg::ACT_NONE;
      it.coef = pick_operand();
      for (int j = 0; j < 4; j++) begin
         it.e[j] = ($urandom_range(11) == 0) ? 4'($urandom_range(15))
                                             : 4'($urandom_range(2));
         it.x[j] = pick_operand();
      end
      it.known = 1'b0;
      return it;
   endfunction

   function automatic term_item_type make_row(ptm_pkg::action_type act,
                                           logic signed [31:0] coef,
                                           logic [15:0] key, logic signed [31:0] x0,
                                           logic signed [31:0] x1, bit known,
                                           logic [15:0] v, logic s, logic [4:0] n);
      term_item_type it;
      it.act  = act;
      it.coef = coef;
      for (int j = 0; j < 4; j++) it.e[j] = key[4*j +: 4];
      it.x[0] = x0;
      it.x[1] = x1;
      it.x[2] = 32'sh8000_0000;
      it.x[3] = 32'sh7fff_ffff;
      it.known   = known;
      it.k_value = v;
      it.k_status = s;
      it.k_terms = n;
      return it;
   endfunction

   // Presents one item, waits for it to be accepted and records its result.
   task automatic send_item(term_item_type it);
      eval_result_type res;
      while (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.action      <= it.act;
      req.coefficient <= it.coef;
      req.exp_0       <= it.e[0];
      req.exp_1       <= it.e[1];
      req.exp_2       <= it.e[2];
      req.exp_3       <= it.e[3];
      req.x_0         <= it.x[0];
      req.x_1         <= it.x[1];
      req.x_2         <= it.x[2];
      req.x_3         <= it.x[3];
      do @(posedge clock); while (!(req.valid && req.ready));
      res = apply_item(it);
      if (it.known) begin
         res.value  = it.k_value;
         res.status = it.k_status;
         res.terms  = it.k_terms;
      end
      expected_q = {expected_q, res};
      sent_count++;
      if (it.act == ptm_pkg::ACT_EVAL) eval_count++;
      if (res.status) full_count++;
   endtask

   task automatic wait_drained();
      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write: a setup phase, then an access phase at whose closing
   // edge the register takes the data.
   task automatic csr_write(ptm_pkg::reg_index_type idx, logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (idx == ptm_pkg::REG_MODULUS) cfg_modulus = data[15:0];
      else                             cfg_var_count = data[2:0];
   endtask

   task automatic set_idling(int mode);
      case (mode % 4)
         0: begin send_gap_pct = 0;  stall_pct = 0;  end
         1: begin send_gap_pct = 76; stall_pct = 0;  end
         2: begin send_gap_pct = 0;  stall_pct = 76; end
         default: begin send_gap_pct = 32; stall_pct = 32; end
      endcase
   endtask

   // Receiver ready, stalled at random according to the current phase.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
      end
   end

   // Result checker: every accepted result item is matched against the
   // oldest expectation, field by field.
   always @(posedge clock) begin
      eval_result_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         got_count++;
         if (expected_q.size() == 0) begin
            $error("result item with no expectation waiting");
            err_count++;
         end else begin
            e = expected_q.pop_front();
            if (rsp.value !== e.value) begin
               $error("value: expected %0d, got %0d", e.value, rsp.value);
               err_count++;
            end
            if (rsp.status !== e.status) begin
               $error("status: expected %0d, got %0d", e.status, rsp.status);
               err_count++;
            end
            if (rsp.stored_terms !== e.terms) begin
               $error("stored_terms: expected %0d, got %0d", e.terms, rsp.stored_terms);
               err_count++;
            end
         end
      end
   end

   // Watchdog on cycles in which no item moves on either channel.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", expected_q.size());
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      term_item_type rows [$];
      int         per_phase;
      logic [15:0] moduli [10];
      logic [2:0]  counts [10];

      moduli = '{16'd65535, 16'd1, 16'd0, 16'd7, 16'd65521,
                 16'd2, 16'd256, 16'd65535, 16'd13, 16'd3};
      counts = '{3'd4, 3'd4, 3'd4, 3'd0, 3'd7, 3'd1, 3'd3, 3'd5, 3'd2, 3'd6};

      reset           = 1'b1;
      psel            = 1'b0;
      penable         = 1'b0;
      pwrite          = 1'b0;
      paddr           = '0;
      pwdata          = '0;
      req.valid       = 1'b0;
      req.action      = ptm_pkg::ACT_CLEAR;
      req.coefficient = '0;
      req.exp_0       = '0;
      req.exp_1       = '0;
      req.exp_2       = '0;
      req.exp_3       = '0;
      req.x_0         = '0;
      req.x_1         = '0;
      req.x_2         = '0;
      req.x_3         = '0;
      err_count       = 0;
      sent_count      = 0;
      got_count       = 0;
      eval_count      = 0;
      full_count      = 0;
      quiet_cycles    = 0;
      term_cnt        = 0;
      cfg_modulus     = ptm_pkg::MODULUS_RESET;
      cfg_var_count   = ptm_pkg::VAR_COUNT_RESET;
      set_idling(0);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed part, under the reset configuration (modulus 2).
      // Evaluating an empty table and an unknown action both give zeros.
      rows = {rows, make_row(ptm_pkg::ACT_EVAL, 0, 16'h0000, 5, 6, 1, 0, 0, 0)};
      rows = {rows, make_row(ptm_pkg::ACT_NONE, 0, 16'h0000, 0, 0, 1, 0, 0, 0)};
      // Coefficient extremes, the top exponent vector and a merge into it.
      rows = {rows, make_row(ptm_pkg::ACT_ADD, 32'sh8000_0000, 16'h0000, 0, 0, 1,
                             0, 0, 1)};
      rows = {rows, make_row(ptm_pkg::ACT_ADD, 32'sh7fff_ffff, 16'hffff, 0, 0, 1,
                             0, 0, 2)};
      rows = {rows, make_row(ptm_pkg::ACT_ADD, 1, 16'hffff, 0, 0, 1, 0, 0, 2)};
      rows = {rows, make_row(ptm_pkg::ACT_EVAL, 0, 16'h0000, 32'sh8000_0000, -1, 0,
                             0, 0, 0)};
      rows = {rows, make_row(ptm_pkg::ACT_CLEAR, 0, 16'h0000, 0, 0, 1, 0, 0, 0)};
      // Fill the table, then overflow it: a new vector is dropped with the
      // full flag, while a vector already stored still merges.
      for (int i = 0; i < TABLE_DEPTH; i++)
         rows = {rows, make_row(ptm_pkg::ACT_ADD, 32'(i + 1), 16'(i), 0, 0, 1,
                                0, 0, 5'(i + 1))};
      rows = {rows, make_row(ptm_pkg::ACT_ADD, 3, 16'h0010, 0, 0, 1, 0, 1, 16)};
      rows = {rows, make_row(ptm_pkg::ACT_ADD, -7, 16'h0003, 0, 0, 1, 0, 0, 16)};
      // Zero point: only the term with all exponents zero survives.
      rows = {rows, make_row(ptm_pkg::ACT_EVAL, 0, 16'h0000, 0, 0, 0, 0, 0, 0)};
      foreach (rows[i]) send_item(rows[i]);

      // Random part, one configuration and one idling pattern per phase.
      // The table is not cleared between phases, so stored coefficients
      // meet a new modulus.
      per_phase = RANDOM_ITEMS / 10;
      for (int p = 0; p < 10; p++) begin
         wait_drained();
         csr_write(ptm_pkg::REG_MODULUS, 32'(moduli[p]));
         csr_write(ptm_pkg::REG_VAR_COUNT, 32'(counts[p]));
         set_idling(p);
         for (int k = 0; k < per_phase; k++) begin
            // A stretch without idling in the middle of each phase.
            if (k == per_phase / 2) set_idling(0);
            if (k == per_phase / 2 + 20) set_idling(p);
            send_item(random_item());
         end
      end

      req.valid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);

      $display("covered %0d items (%0d evaluates, %0d dropped on a full table), %0d results",
               sent_count, eval_count, full_count, got_count);
      $display("over ten modulus and var_count settings and four idling patterns");
      if (err_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
